// ===== hdl/wmc_pkg.sv =====
// wmc_pkg: shared types, widths and codes for the westgard multirule checker
// no dependencies; used by every other file of the block

package wmc_pkg;

    // field widths
    localparam int SAMPLE_W = 32;
    localparam int SD_W     = 31;
    localparam int THR_W    = 34;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 32;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_SD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_SD = 2'd2;

    // register reset values
    localparam logic signed [SAMPLE_W-1:0] CENTRE_RESET = '0;
    localparam logic [SD_W-1:0]            SD_RESET     = 31'd65536;

    // zone codes
    localparam logic [1:0] ZONE_1SD = 2'd0;
    localparam logic [1:0] ZONE_2SD = 2'd1;
    localparam logic [1:0] ZONE_3SD = 2'd2;
    localparam logic [1:0] ZONE_OUT = 2'd3;

    // rule count slots, in the order of the result fields
    localparam int NUM_RULES = 8;
    localparam int RULE_1_2S = 0;
    localparam int RULE_1_3S = 1;
    localparam int RULE_2_2S = 2;
    localparam int RULE_R_4S = 3;
    localparam int RULE_4_1S = 4;
    localparam int RULE_8X   = 5;
    localparam int RULE_10X  = 6;
    localparam int RULE_12X  = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // run lengths: counters hold 0 .. length-1
    localparam int RUN4_W  = 2;
    localparam int RUN8_W  = 3;
    localparam int RUN10_W = 4;
    localparam int RUN12_W = 4;
    localparam logic [RUN4_W-1:0]  RUN4_TOP  = RUN4_W'(4 - 1);
    localparam logic [RUN8_W-1:0]  RUN8_TOP  = RUN8_W'(8 - 1);
    localparam logic [RUN10_W-1:0] RUN10_TOP = RUN10_W'(10 - 1);
    localparam logic [RUN12_W-1:0] RUN12_TOP = RUN12_W'(12 - 1);

    // series length limit
    localparam int SERIES_MAX = 64;
    localparam int SERIES_W   = $clog2(SERIES_MAX);
    localparam logic [SERIES_W-1:0] SERIES_TOP = SERIES_W'(SERIES_MAX - 1);

    // decision thresholds, centre +/- k SD for k = 1, 2, 3
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] centre;
        logic signed [THR_W-1:0]    hi1;
        logic signed [THR_W-1:0]    hi2;
        logic signed [THR_W-1:0]    hi3;
        logic signed [THR_W-1:0]    lo1;
        logic signed [THR_W-1:0]    lo2;
        logic signed [THR_W-1:0]    lo3;
    } thr_t;

    localparam logic signed [THR_W-1:0] SD_RESET_X = {3'b000, SD_RESET};

    localparam thr_t THR_RESET = '{
        centre: CENTRE_RESET,
        hi1:    SD_RESET_X,
        hi2:    THR_W'(2 * SD_RESET_X),
        hi3:    THR_W'(3 * SD_RESET_X),
        lo1:    THR_W'(-SD_RESET_X),
        lo2:    THR_W'(-2 * SD_RESET_X),
        lo3:    THR_W'(-3 * SD_RESET_X)
    };

    // one result word
    typedef struct packed {
        logic [1:0]         zone;
        logic [COUNT_W-1:0] count_1_2s;
        logic [COUNT_W-1:0] count_1_3s;
        logic [COUNT_W-1:0] count_2_2s;
        logic [COUNT_W-1:0] count_r_4s;
        logic [COUNT_W-1:0] count_4_1s;
        logic [COUNT_W-1:0] count_8x;
        logic [COUNT_W-1:0] count_10x;
        logic [COUNT_W-1:0] count_12x;
        logic               warning_active;
    } res_t;

endpackage

// ===== hdl/wmc_if.sv =====
// wmc_if: valid/ready stream interfaces for sample words and result words
// depends on wmc_pkg for field widths

interface wmc_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wmc_pkg::SAMPLE_W-1:0] sample;
    logic                                 last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface wmc_result_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   zone;
    logic [wmc_pkg::COUNT_W-1:0] count_1_2s;
    logic [wmc_pkg::COUNT_W-1:0] count_1_3s;
    logic [wmc_pkg::COUNT_W-1:0] count_2_2s;
    logic [wmc_pkg::COUNT_W-1:0] count_r_4s;
    logic [wmc_pkg::COUNT_W-1:0] count_4_1s;
    logic [wmc_pkg::COUNT_W-1:0] count_8x;
    logic [wmc_pkg::COUNT_W-1:0] count_10x;
    logic [wmc_pkg::COUNT_W-1:0] count_12x;
    logic                         warning_active;

    modport source (
        output valid, output zone, output count_1_2s, output count_1_3s,
        output count_2_2s, output count_r_4s, output count_4_1s,
        output count_8x, output count_10x, output count_12x,
        output warning_active, input ready
    );
    modport sink (
        input valid, input zone, input count_1_2s, input count_1_3s,
        input count_2_2s, input count_r_4s, input count_4_1s,
        input count_8x, input count_10x, input count_12x,
        input warning_active, output ready
    );
endinterface

// ===== hdl/wmc_cfg_regs.sv =====
// wmc_cfg_regs: configuration registers and registered sd thresholds
// depends on wmc_pkg

module wmc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [wmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [wmc_pkg::CFG_W-1:0]          cfg_data,
    output wmc_pkg::thr_t                       thr
);

    logic signed [wmc_pkg::SAMPLE_W-1:0] centre_reg;
    logic [wmc_pkg::SD_W-1:0]            upper_reg;
    logic [wmc_pkg::SD_W-1:0]            lower_reg;
    wmc_pkg::thr_t                       thr_reg;
    wmc_pkg::thr_t                       thr_next;

    logic signed [wmc_pkg::THR_W-1:0] centre_x;
    logic signed [wmc_pkg::THR_W-1:0] up1;
    logic signed [wmc_pkg::THR_W-1:0] up2;
    logic signed [wmc_pkg::THR_W-1:0] up3;
    logic signed [wmc_pkg::THR_W-1:0] dn1;
    logic signed [wmc_pkg::THR_W-1:0] dn2;
    logic signed [wmc_pkg::THR_W-1:0] dn3;

    // register writes, top bit of the data word dropped for the sd registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= wmc_pkg::CENTRE_RESET;
            upper_reg  <= wmc_pkg::SD_RESET;
            lower_reg  <= wmc_pkg::SD_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wmc_pkg::REG_CENTRE:   centre_reg <= cfg_data[wmc_pkg::SAMPLE_W-1:0];
                wmc_pkg::REG_UPPER_SD: upper_reg  <= cfg_data[wmc_pkg::SD_W-1:0];
                wmc_pkg::REG_LOWER_SD: lower_reg  <= cfg_data[wmc_pkg::SD_W-1:0];
                default:               ;
            endcase
        end
    end

    // multiples of each sd, exact in the wider threshold width
    always_comb
    begin
        centre_x = {{(wmc_pkg::THR_W - wmc_pkg::SAMPLE_W){centre_reg[wmc_pkg::SAMPLE_W-1]}},
                    centre_reg};
        up1 = {3'b000, upper_reg};
        up2 = {2'b00, upper_reg, 1'b0};
        up3 = up2 + up1;
        dn1 = {3'b000, lower_reg};
        dn2 = {2'b00, lower_reg, 1'b0};
        dn3 = dn2 + dn1;

        thr_next.centre = centre_reg;
        thr_next.hi1    = centre_x + up1;
        thr_next.hi2    = centre_x + up2;
        thr_next.hi3    = centre_x + up3;
        thr_next.lo1    = centre_x - dn1;
        thr_next.lo2    = centre_x - dn2;
        thr_next.lo3    = centre_x - dn3;
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= wmc_pkg::THR_RESET;
        else
            thr_reg <= thr_next;
    end

    assign thr = thr_reg;

endmodule

// ===== hdl/wmc_rule_engine.sv =====
// wmc_rule_engine: zone decision, westgard rule state and saturating counts
// depends on wmc_pkg; thresholds come from wmc_cfg_regs

module wmc_rule_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                step,
    input  logic signed [wmc_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    input  wmc_pkg::thr_t                       thr,
    output wmc_pkg::res_t                       res
);

    logic                          prev_above_reg;
    logic                          prev_below_reg;
    logic [wmc_pkg::RUN4_W-1:0]    run_up4_reg;
    logic [wmc_pkg::RUN4_W-1:0]    run_dn4_reg;
    logic [wmc_pkg::RUN8_W-1:0]    run_up8_reg;
    logic [wmc_pkg::RUN8_W-1:0]    run_dn8_reg;
    logic [wmc_pkg::RUN10_W-1:0]   run_up10_reg;
    logic [wmc_pkg::RUN10_W-1:0]   run_dn10_reg;
    logic [wmc_pkg::RUN12_W-1:0]   run_up12_reg;
    logic [wmc_pkg::RUN12_W-1:0]   run_dn12_reg;
    logic [wmc_pkg::SERIES_W-1:0]  series_reg;
    logic [wmc_pkg::COUNT_W-1:0]   counts_reg [wmc_pkg::NUM_RULES];

    logic [wmc_pkg::RUN4_W-1:0]    run_up4_next;
    logic [wmc_pkg::RUN4_W-1:0]    run_dn4_next;
    logic [wmc_pkg::RUN8_W-1:0]    run_up8_next;
    logic [wmc_pkg::RUN8_W-1:0]    run_dn8_next;
    logic [wmc_pkg::RUN10_W-1:0]   run_up10_next;
    logic [wmc_pkg::RUN10_W-1:0]   run_dn10_next;
    logic [wmc_pkg::RUN12_W-1:0]   run_up12_next;
    logic [wmc_pkg::RUN12_W-1:0]   run_dn12_next;
    logic [wmc_pkg::COUNT_W-1:0]   counts_next [wmc_pkg::NUM_RULES];

    logic signed [wmc_pkg::THR_W-1:0] s_x;
    logic a1, b1, a2, b2, a3, b3, ax, bx;
    logic series_end;
    logic [wmc_pkg::NUM_RULES-1:0] hit;
    logic [1:0] zone;

    // compare against the thresholds
    always_comb
    begin
        s_x = {{(wmc_pkg::THR_W - wmc_pkg::SAMPLE_W){sample[wmc_pkg::SAMPLE_W-1]}}, sample};
        a1 = s_x > thr.hi1;
        b1 = s_x < thr.lo1;
        a2 = s_x > thr.hi2;
        b2 = s_x < thr.lo2;
        a3 = s_x > thr.hi3;
        b3 = s_x < thr.lo3;
        ax = sample > thr.centre;
        bx = sample < thr.centre;
    end

    // zone, ties on a line go outward
    always_comb
    begin
        priority if (s_x >= thr.hi3 || s_x <= thr.lo3)
            zone = wmc_pkg::ZONE_OUT;
        else if (s_x >= thr.hi2 || s_x <= thr.lo2)
            zone = wmc_pkg::ZONE_3SD;
        else if (s_x >= thr.hi1 || s_x <= thr.lo1)
            zone = wmc_pkg::ZONE_2SD;
        else
            zone = wmc_pkg::ZONE_1SD;
    end

    // run counters, restart at zero on a hit or when a word is not on the counter's side
    always_comb
    begin
        run_up4_next  = (a1 && run_up4_reg != wmc_pkg::RUN4_TOP)
                        ? run_up4_reg + 1'b1 : '0;
        run_dn4_next  = (b1 && run_dn4_reg != wmc_pkg::RUN4_TOP)
                        ? run_dn4_reg + 1'b1 : '0;
        run_up8_next  = (ax && run_up8_reg != wmc_pkg::RUN8_TOP)
                        ? run_up8_reg + 1'b1 : '0;
        run_dn8_next  = (bx && run_dn8_reg != wmc_pkg::RUN8_TOP)
                        ? run_dn8_reg + 1'b1 : '0;
        run_up10_next = (ax && run_up10_reg != wmc_pkg::RUN10_TOP)
                        ? run_up10_reg + 1'b1 : '0;
        run_dn10_next = (bx && run_dn10_reg != wmc_pkg::RUN10_TOP)
                        ? run_dn10_reg + 1'b1 : '0;
        run_up12_next = (ax && run_up12_reg != wmc_pkg::RUN12_TOP)
                        ? run_up12_reg + 1'b1 : '0;
        run_dn12_next = (bx && run_dn12_reg != wmc_pkg::RUN12_TOP)
                        ? run_dn12_reg + 1'b1 : '0;
    end

    // rule hits for this word
    always_comb
    begin
        hit[wmc_pkg::RULE_1_2S] = a2 || b2;
        hit[wmc_pkg::RULE_1_3S] = a3 || b3;
        hit[wmc_pkg::RULE_2_2S] = (prev_above_reg && a2) || (prev_below_reg && b2);
        hit[wmc_pkg::RULE_R_4S] = (prev_above_reg && b2) || (prev_below_reg && a2);
        hit[wmc_pkg::RULE_4_1S] = (a1 && run_up4_reg == wmc_pkg::RUN4_TOP)
                                  || (b1 && run_dn4_reg == wmc_pkg::RUN4_TOP);
        hit[wmc_pkg::RULE_8X]   = (ax && run_up8_reg == wmc_pkg::RUN8_TOP)
                                  || (bx && run_dn8_reg == wmc_pkg::RUN8_TOP);
        hit[wmc_pkg::RULE_10X]  = (ax && run_up10_reg == wmc_pkg::RUN10_TOP)
                                  || (bx && run_dn10_reg == wmc_pkg::RUN10_TOP);
        hit[wmc_pkg::RULE_12X]  = (ax && run_up12_reg == wmc_pkg::RUN12_TOP)
                                  || (bx && run_dn12_reg == wmc_pkg::RUN12_TOP);
    end

    // saturating count update
    always_comb
    begin
        for (int i = 0; i < wmc_pkg::NUM_RULES; i++)
        begin
            if (hit[i] && counts_reg[i] != wmc_pkg::COUNT_MAX)
                counts_next[i] = counts_reg[i] + 1'b1;
            else
                counts_next[i] = counts_reg[i];
        end
    end

    assign series_end = last || (series_reg == wmc_pkg::SERIES_TOP);

    // result word shows counts including this sample, before any clear
    always_comb
    begin
        res.zone           = zone;
        res.count_1_2s     = counts_next[wmc_pkg::RULE_1_2S];
        res.count_1_3s     = counts_next[wmc_pkg::RULE_1_3S];
        res.count_2_2s     = counts_next[wmc_pkg::RULE_2_2S];
        res.count_r_4s     = counts_next[wmc_pkg::RULE_R_4S];
        res.count_4_1s     = counts_next[wmc_pkg::RULE_4_1S];
        res.count_8x       = counts_next[wmc_pkg::RULE_8X];
        res.count_10x      = counts_next[wmc_pkg::RULE_10X];
        res.count_12x      = counts_next[wmc_pkg::RULE_12X];
        res.warning_active = counts_next[wmc_pkg::RULE_1_2S] != '0;
    end

    // series state, cleared after the closing word of a series
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_above_reg <= 1'b0;
            prev_below_reg <= 1'b0;
            run_up4_reg    <= '0;
            run_dn4_reg    <= '0;
            run_up8_reg    <= '0;
            run_dn8_reg    <= '0;
            run_up10_reg   <= '0;
            run_dn10_reg   <= '0;
            run_up12_reg   <= '0;
            run_dn12_reg   <= '0;
            series_reg     <= '0;
            for (int i = 0; i < wmc_pkg::NUM_RULES; i++)
                counts_reg[i] <= '0;
        end
        else if (step)
        begin
            if (series_end)
            begin
                prev_above_reg <= 1'b0;
                prev_below_reg <= 1'b0;
                run_up4_reg    <= '0;
                run_dn4_reg    <= '0;
                run_up8_reg    <= '0;
                run_dn8_reg    <= '0;
                run_up10_reg   <= '0;
                run_dn10_reg   <= '0;
                run_up12_reg   <= '0;
                run_dn12_reg   <= '0;
                series_reg     <= '0;
                for (int i = 0; i < wmc_pkg::NUM_RULES; i++)
                    counts_reg[i] <= '0;
            end
            else
            begin
                prev_above_reg <= a2;
                prev_below_reg <= b2;
                run_up4_reg    <= run_up4_next;
                run_dn4_reg    <= run_dn4_next;
                run_up8_reg    <= run_up8_next;
                run_dn8_reg    <= run_dn8_next;
                run_up10_reg   <= run_up10_next;
                run_dn10_reg   <= run_dn10_next;
                run_up12_reg   <= run_up12_next;
                run_dn12_reg   <= run_dn12_next;
                series_reg     <= series_reg + 1'b1;
                for (int i = 0; i < wmc_pkg::NUM_RULES; i++)
                    counts_reg[i] <= counts_next[i];
            end
        end
    end

endmodule

// ===== hdl/westgard_multirule_checker.sv =====
// Westgard multirule checker: one sample word in, one result word out, with
// an input register, a single decision pass and an output register. A new
// word is taken every cycle unless a result waits untaken in a full output
// register; the series state and counts update in the cycle a word moves from
// the input register to the output register, so words chain at full rate.
// Sd thresholds are registered in the cycle after a configuration write.
// A series ends after a word with last set or after SERIES_MAX words.
// Depends on wmc_pkg, wmc_if, wmc_cfg_regs and wmc_rule_engine.

module westgard_multirule_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [wmc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [wmc_pkg::CFG_W-1:0]        cfg_data,
    wmc_sample_if.sink                        samples,
    wmc_result_if.source                      results
);

    logic                                 in_valid_reg;
    logic signed [wmc_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                                 in_last_reg;
    logic                                 out_valid_reg;
    wmc_pkg::res_t                        out_res_reg;

    wmc_pkg::thr_t thr;
    wmc_pkg::res_t res;
    logic          advance;
    logic          step;
    logic          accept;

    // handshake: an empty input register refills while a result waits
    assign advance       = !out_valid_reg || results.ready;
    assign step          = in_valid_reg && advance;
    assign samples.ready = !in_valid_reg || advance;
    assign accept        = samples.valid && samples.ready;

    wmc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    wmc_rule_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .sample (in_sample_reg),
        .last   (in_last_reg),
        .thr    (thr),
        .res    (res)
    );

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sample_reg <= samples.sample;
            in_last_reg   <= samples.last;
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign results.valid          = out_valid_reg;
    assign results.zone           = out_res_reg.zone;
    assign results.count_1_2s     = out_res_reg.count_1_2s;
    assign results.count_1_3s     = out_res_reg.count_1_3s;
    assign results.count_2_2s     = out_res_reg.count_2_2s;
    assign results.count_r_4s     = out_res_reg.count_r_4s;
    assign results.count_4_1s     = out_res_reg.count_4_1s;
    assign results.count_8x       = out_res_reg.count_8x;
    assign results.count_10x      = out_res_reg.count_10x;
    assign results.count_12x      = out_res_reg.count_12x;
    assign results.warning_active = out_res_reg.warning_active;

`ifndef SYNTHESIS
    // warning flag tracks the 1-2s count
    a_warning_flag: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.warning_active == (results.count_1_2s != '0)))
        else $error("warning_active disagrees with count_1_2s");

    // every 1-3s hit is also a 1-2s hit
    a_3s_within_2s: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.count_1_3s <= results.count_1_2s))
        else $error("count_1_3s exceeds count_1_2s");

    // pair rules only fire with a 1-2s hit on the same word
    a_pairs_within_2s: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.count_2_2s <= results.count_1_2s
                           && results.count_r_4s <= results.count_1_2s))
        else $error("pair rule count exceeds count_1_2s");

    // a held word stays in the input register while the output stalls
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_sample_reg)))
        else $error("input register lost a word under stall");
`endif

endmodule
